FILE: rtl/fcrq_pkg.sv
// ----------------------------------------------------------------------------
// fcrq_pkg
// Shared types and constants for the Fenwick range count block.
// ----------------------------------------------------------------------------
package fcrq_pkg;

    // Tree capacity and node counter width
    localparam int MAX_SIZE = 1024;
    localparam int COUNT_W  = 32;
    localparam int ADDR_W   = $clog2(MAX_SIZE);

    // Field widths of the stream payloads
    localparam int POS_W    = 11;
    localparam int REQ_W    = 2;
    localparam int IN_DATA_W  = 40;  // three positions, padded to whole bytes
    localparam int OUT_DATA_W = 32;

    // Request kinds carried in s_tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_INC   = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    // Operations of the shared arithmetic unit
    typedef enum logic {
        OP_SAT_ADD = 1'b0,
        OP_SUB_FLOOR = 1'b1
    } arith_op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC_RD,
        ST_INC_WR,
        ST_Q_RD,
        ST_Q_ACC,
        ST_DONE
    } fcrq_state_t;

endpackage

FILE: rtl/fcrq_arith.sv
// ----------------------------------------------------------------------------
// fcrq_arith
// Shared saturating add / floored subtract unit for node and prefix sums.
// ----------------------------------------------------------------------------
module fcrq_arith (
    input  fcrq_pkg::arith_op_t          op,
    input  logic [fcrq_pkg::COUNT_W-1:0] a,
    input  logic [fcrq_pkg::COUNT_W-1:0] b,
    output logic [fcrq_pkg::COUNT_W-1:0] res
);
    import fcrq_pkg::*;

    logic [COUNT_W:0] sum;

    // Add with one carry bit, subtract only when it cannot go negative
    always_comb begin
        sum = {1'b0, a} + {1'b0, b};
        unique case (op)
            OP_SAT_ADD: begin
                res = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
            end
            OP_SUB_FLOOR: begin
                res = (a > b) ? (a - b) : '0;
            end
            default: begin
                res = '0;
            end
        endcase
    end

endmodule

FILE: rtl/fenwick_count_range_query.sv
// ----------------------------------------------------------------------------
// fenwick_count_range_query
// Binary indexed tree of saturating counters with increment, range count
// and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request: s_tuser is the kind (increment, range query,
//   clear), s_tdata the position and the range bounds. m_* returns one
//   result per range query: the count in m_tdata, the bad-range flag in
//   m_tuser. Increments and clears return nothing. cfg_* writes the number
//   of positions in use; write it only while the block is idle.
//   Each request is stepped through the node memory, with its one write
//   port and registered read, and the one shared adder:
//     increment : a read and a write per node climbed
//     query     : a read and an add per node, upper prefix then lower
//     bad query : no walk, straight to the result
//     clear     : all MAX_SIZE nodes, one node written per cycle
//   s_tready is high only between requests. After reset the same clearing
//   pass runs over every node before the first request is taken; the
//   size register resets to 1024 and cfg writes are taken throughout.
//   A finished result waits in the output register; while it is stalled
//   the next request is still taken, and a second result holds the block
//   until the first one leaves.
// ----------------------------------------------------------------------------
module fenwick_count_range_query (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: position [10:0], range_low [21:11], range_high [32:22]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fcrq_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: req_type [1:0]
    input  logic [fcrq_pkg::REQ_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: range_count [31:0]
    output logic [fcrq_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tuser: bad_range [0]
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fcrq_pkg::POS_W-1:0]      cfg_data
);
    import fcrq_pkg::*;

    localparam logic [POS_W-1:0]  MAX_POS  = POS_W'(MAX_SIZE);
    localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(MAX_SIZE - 1);

    fcrq_state_t            state_reg, state_next;
    logic [POS_W-1:0]       size_reg, size_next;
    logic [POS_W-1:0]       at_reg, at_next;
    logic [POS_W-1:0]       lo_reg, lo_next;
    logic [COUNT_W-1:0]     acc_reg, acc_next;
    logic [COUNT_W-1:0]     top_reg, top_next;
    logic                   phase_reg, phase_next;
    logic                   bad_reg, bad_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;
    logic                   m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]     m_count_reg, m_count_next;
    logic                   m_bad_reg, m_bad_next;

    logic [POS_W-1:0]       in_pos, in_lo, in_hi, lim, lsb, at_down, at_dec;
    logic [POS_W:0]         at_up;

    logic [COUNT_W-1:0]     node_mem [MAX_SIZE];
    logic [COUNT_W-1:0]     rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_W-1:0]     mem_wdata;

    arith_op_t              unit_op;
    logic [COUNT_W-1:0]     unit_a, unit_b, unit_res;

    // Unpack request fields
    assign in_pos = s_tdata[POS_W-1:0];
    assign in_lo  = s_tdata[2*POS_W-1:POS_W];
    assign in_hi  = s_tdata[3*POS_W-1:2*POS_W];

    // Effective size and tree index steps
    assign lim     = (size_reg > MAX_POS) ? MAX_POS : size_reg;
    assign lsb     = at_reg & (~at_reg + POS_W'(1));
    assign at_up   = {1'b0, at_reg} + {1'b0, lsb};
    assign at_dec  = at_reg - POS_W'(1);
    assign at_down = at_reg & at_dec;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_count_reg;
    assign m_tuser   = m_bad_reg;

    fcrq_arith u_arith (
        .op  (unit_op),
        .a   (unit_a),
        .b   (unit_b),
        .res (unit_res)
    );

    // Node memory: one write port, one registered read at the walk index
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= node_mem[at_dec[ADDR_W-1:0]];
    end

    // Control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            size_reg    <= MAX_POS;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Walk payload registers
    always_ff @(posedge aclk) begin
        at_reg      <= at_next;
        lo_reg      <= lo_next;
        acc_reg     <= acc_next;
        top_reg     <= top_next;
        phase_reg   <= phase_next;
        bad_reg     <= bad_next;
        m_count_reg <= m_count_next;
        m_bad_reg   <= m_bad_next;
    end

    // Sequencer: next state, memory writes and shared unit control
    always_comb begin
        state_next   = state_reg;
        size_next    = size_reg;
        at_next      = at_reg;
        lo_next      = lo_reg;
        acc_next     = acc_reg;
        top_next     = top_reg;
        phase_next   = phase_reg;
        bad_next     = bad_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        m_count_next = m_count_reg;
        m_bad_next   = m_bad_reg;
        mem_we       = 1'b0;
        mem_waddr    = at_dec[ADDR_W-1:0];
        mem_wdata    = unit_res;
        unit_op      = OP_SAT_ADD;
        unit_a       = acc_reg;
        unit_b       = rd_data_reg;

        // Take configuration writes at any time
        if (cfg_valid) begin
            size_next = cfg_data;
        end

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (req_t'(s_tuser))
                        REQ_INC: begin
                            if (in_pos != '0 && in_pos <= lim) begin
                                at_next    = in_pos;
                                state_next = ST_INC_RD;
                            end
                        end
                        REQ_QUERY: begin
                            if (in_lo == '0 || in_lo > in_hi || in_hi > lim) begin
                                bad_next   = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                bad_next   = 1'b0;
                                at_next    = in_hi;
                                lo_next    = in_lo;
                                acc_next   = '0;
                                phase_next = 1'b0;
                                state_next = ST_Q_RD;
                            end
                        end
                        REQ_CLEAR: begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INC_RD: begin
                state_next = ST_INC_WR;
            end
            ST_INC_WR: begin
                // Raise the node and climb by the lowest set bit
                unit_a = rd_data_reg;
                unit_b = COUNT_W'(1);
                mem_we = 1'b1;
                if (at_up > {1'b0, lim}) begin
                    state_next = ST_IDLE;
                end else begin
                    at_next    = at_up[POS_W-1:0];
                    state_next = ST_INC_RD;
                end
            end
            ST_Q_RD: begin
                if (at_reg == '0) begin
                    if (!phase_reg) begin
                        // Upper prefix done; start the lower one at low-1
                        top_next   = acc_reg;
                        acc_next   = '0;
                        at_next    = lo_reg - POS_W'(1);
                        phase_next = 1'b1;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    state_next = ST_Q_ACC;
                end
            end
            ST_Q_ACC: begin
                // Accumulate the node and strip the lowest set bit
                acc_next   = unit_res;
                at_next    = at_down;
                state_next = ST_Q_RD;
            end
            ST_DONE: begin
                unit_op = OP_SUB_FLOOR;
                unit_a  = top_reg;
                unit_b  = acc_reg;
                // Hold while the previous result is still stalled
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_count_next = bad_reg ? '0 : unit_res;
                    m_bad_next   = bad_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/fcrq_checker.sv
// ----------------------------------------------------------------------------
// fcrq_checker
// Port-level checks for the Fenwick range count block, bound to the top.
// ----------------------------------------------------------------------------
module fcrq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [fcrq_pkg::REQ_W-1:0]      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fcrq_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import fcrq_pkg::*;

    // No request is taken right after reset: the clearing pass runs first
    a_busy_after_reset: assert property (
        @(posedge aclk) !aresetn |=> !s_tready
    ) else $error("request port ready right after reset");

    // A query or a clear keeps the block busy in the following cycle
    a_busy_after_req: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == REQ_QUERY || s_tuser == REQ_CLEAR))
        |=> !s_tready
    ) else $error("block ready again one cycle after a query or clear");

    // A bad range always reports a zero count
    a_bad_is_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0)
    ) else $error("bad range with nonzero count");

    // A stalled result holds
    a_out_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    ) else $error("stalled result changed or dropped");

endmodule

bind fenwick_count_range_query fcrq_checker u_fcrq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
